// ===== rtl/core/bzt_pkg.sv =====
// Shared types and constants for the cubic Bezier tessellator.
// No dependencies; used by bzt_seq, bzt_pipe and cubic_bezier_tessellator.
package bzt_pkg;

    localparam int COORD_W  = 24;
    localparam int IDX_W    = 6;
    localparam int T_BITS   = 16;
    localparam int W_BITS   = 30;
    localparam int DIV_LAST = T_BITS;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Control points: index 0 start, 1 and 2 control, 3 end.
    typedef struct packed {
        logic [3:0][COORD_W-1:0] px;
        logic [3:0][COORD_W-1:0] py;
    } ctrl_pts_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
        logic [T_BITS:0]  t;
    } issue_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RUN  = 3'b100
    } seq_state_t;

endpackage

// ===== rtl/core/bzt_seq.sv =====
// Sample sequencer: takes one curve transaction, divides 2^16 by a nonzero segment
// count bit-serially, then issues one sample per cycle while en is high. Uses bzt_pkg.
module bzt_seq (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bzt_pkg::ctrl_pts_t        pts_in,
    input  logic [bzt_pkg::IDX_W-1:0] seg_in,
    input  logic                      en,
    output bzt_pkg::issue_t           issue,
    output bzt_pkg::ctrl_pts_t        pts
);

    bzt_pkg::seq_state_t        state_reg;
    bzt_pkg::ctrl_pts_t         pts_reg;
    logic [bzt_pkg::IDX_W-1:0]  n_reg;
    logic [4:0]                 cnt_reg;
    logic [bzt_pkg::IDX_W-1:0]  rem_reg;
    logic [bzt_pkg::T_BITS:0]   quo_reg;
    logic [bzt_pkg::T_BITS:0]   frac_reg;
    logic [bzt_pkg::IDX_W-1:0]  res_reg;
    logic [bzt_pkg::IDX_W-1:0]  idx_reg;

    logic [bzt_pkg::IDX_W:0]    trial;
    logic                       trial_ge;
    logic [bzt_pkg::IDX_W:0]    r_sum;
    logic                       r_ge;
    logic                       at_end;

    always_comb begin
        trial    = {rem_reg, (cnt_reg == 5'(bzt_pkg::DIV_LAST))};
        trial_ge = trial >= {1'b0, n_reg};
        r_sum    = {1'b0, res_reg} + {1'b0, rem_reg};
        r_ge     = r_sum >= {1'b0, n_reg};
        at_end   = idx_reg == n_reg;
    end

    assign s_ready     = state_reg == bzt_pkg::ST_IDLE;
    assign issue.valid = state_reg == bzt_pkg::ST_RUN;
    assign issue.last  = at_end;
    assign issue.index = idx_reg;
    assign issue.t     = frac_reg;
    assign pts         = pts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bzt_pkg::ST_IDLE;
        end else begin
            case (state_reg)
                bzt_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        pts_reg   <= pts_in;
                        n_reg     <= seg_in;
                        cnt_reg   <= 5'(bzt_pkg::DIV_LAST);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        idx_reg   <= '0;
                        frac_reg  <= '0;
                        res_reg   <= {1'b0, seg_in[bzt_pkg::IDX_W-1:1]};
                        state_reg <= (seg_in == '0) ? bzt_pkg::ST_RUN : bzt_pkg::ST_DIV;
                    end
                end
                bzt_pkg::ST_DIV: begin
                    // one quotient bit per cycle; remainder stays below n
                    rem_reg <= trial_ge ? 6'(trial - {1'b0, n_reg}) : trial[5:0];
                    quo_reg <= {quo_reg[bzt_pkg::T_BITS-1:0], trial_ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= bzt_pkg::ST_RUN;
                    end
                end
                bzt_pkg::ST_RUN: begin
                    if (en) begin
                        if (at_end) begin
                            state_reg <= bzt_pkg::ST_IDLE;
                        end else begin
                            // advance t by 2^16/n, carrying the remainder
                            idx_reg  <= idx_reg + 6'd1;
                            res_reg  <= r_ge ? 6'(r_sum - {1'b0, n_reg}) : r_sum[5:0];
                            frac_reg <= frac_reg + quo_reg + 17'(r_ge);
                        end
                    end
                end
                default: begin
                    state_reg <= bzt_pkg::ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bzt_pkg::ST_RUN) |-> (idx_reg <= n_reg))
        else $error("sample index ran past segment count");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bzt_pkg::ST_DIV) |-> (rem_reg < n_reg))
        else $error("divider remainder not below divisor");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !issue.valid)
        else $error("issuing while accepting a new transaction");
    a_res_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bzt_pkg::ST_RUN && n_reg != '0) |-> (res_reg < n_reg))
        else $error("t remainder not below divisor");
`endif

endmodule

// ===== rtl/core/bzt_pipe.sv =====
// Six-stage evaluation pipeline: squares, cubes, weights, products, sum,
// round/saturate into output register. Whole pipe stalls together. Uses bzt_pkg.
module bzt_pipe (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bzt_pkg::issue_t                  issue,
    input  bzt_pkg::ctrl_pts_t               pts,
    output logic                             en,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [bzt_pkg::COORD_W-1:0] m_point_x,
    output logic signed [bzt_pkg::COORD_W-1:0] m_point_y,
    output logic [bzt_pkg::IDX_W-1:0]        m_point_index,
    output logic                             m_last_point
);

    localparam int UU_W = 2 * bzt_pkg::T_BITS + 2;
    localparam int A_W  = 3 * bzt_pkg::T_BITS + 3;
    localparam int WT_W = bzt_pkg::W_BITS + 1;
    localparam int PR_W = WT_W + 1 + bzt_pkg::COORD_W;
    localparam int S_W  = PR_W + 2;
    localparam int SH   = 3 * bzt_pkg::T_BITS - bzt_pkg::W_BITS;
    localparam int V_W  = S_W - bzt_pkg::W_BITS;

    // valid, last, index per stage 1..5
    logic [5:1]                     v_reg;
    logic [5:1]                     l_reg;
    logic [5:1][bzt_pkg::IDX_W-1:0] i_reg;
    bzt_pkg::ctrl_pts_t             p_reg [1:5];

    logic [bzt_pkg::T_BITS:0]       u1_reg;
    logic [bzt_pkg::T_BITS-1:0]     t1_reg;
    logic [UU_W-1:0]                uu_reg;
    logic [UU_W-1:0]                tt_reg;
    logic [3:0][A_W-1:0]            a_reg;
    logic [3:0][WT_W-1:0]           w_reg;
    logic signed [PR_W-1:0]         px_reg [4];
    logic signed [PR_W-1:0]         py_reg [4];
    logic signed [S_W-1:0]          sx_reg;
    logic signed [S_W-1:0]          sy_reg;

    logic                           ov_reg;
    logic signed [bzt_pkg::COORD_W-1:0] ox_reg;
    logic signed [bzt_pkg::COORD_W-1:0] oy_reg;
    logic [bzt_pkg::IDX_W-1:0]      oi_reg;
    logic                           ol_reg;

    logic [bzt_pkg::T_BITS:0]       u_next;
    logic [3:0][A_W:0]              b_next;
    logic [3:0][WT_W-1:0]           w_next;
    logic signed [bzt_pkg::COORD_W-1:0] ox_next;
    logic signed [bzt_pkg::COORD_W-1:0] oy_next;

    function automatic logic signed [bzt_pkg::COORD_W-1:0] round_sat(
        input logic signed [S_W-1:0] s
    );
        logic signed [S_W-1:0] r;
        logic signed [V_W-1:0] v;
        begin
            r = s + (S_W'(1) <<< (bzt_pkg::W_BITS - 1));
            v = r[S_W-1:bzt_pkg::W_BITS];
            if (v > V_W'(2 ** (bzt_pkg::COORD_W - 1) - 1)) begin
                round_sat = {1'b0, {(bzt_pkg::COORD_W-1){1'b1}}};
            end else if (v < -(V_W'(2 ** (bzt_pkg::COORD_W - 1)))) begin
                round_sat = {1'b1, {(bzt_pkg::COORD_W-1){1'b0}}};
            end else begin
                round_sat = v[bzt_pkg::COORD_W-1:0];
            end
        end
    endfunction

    assign en = !ov_reg || m_ready;

    always_comb begin
        u_next = (17'(1) << bzt_pkg::T_BITS) - issue.t;
        b_next[0] = {1'b0, a_reg[0]};
        b_next[1] = {a_reg[1], 1'b0} + {1'b0, a_reg[1]};
        b_next[2] = {a_reg[2], 1'b0} + {1'b0, a_reg[2]};
        b_next[3] = {1'b0, a_reg[3]};
        for (int k = 0; k < 4; k++) begin
            w_next[k] = WT_W'((b_next[k] + (A_W+1)'(2 ** (SH - 1))) >> SH);
        end
        ox_next = l_reg[5] ? $signed(p_reg[5].px[3]) : round_sat(sx_reg);
        oy_next = l_reg[5] ? $signed(p_reg[5].py[3]) : round_sat(sy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[4:1], issue.valid};
            ov_reg <= v_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg    <= {l_reg[4:1], issue.last};
            i_reg    <= {i_reg[4:1], issue.index};
            p_reg[1] <= pts;
            for (int k = 2; k <= 5; k++) begin
                p_reg[k] <= p_reg[k-1];
            end
            // stage 1: squares
            u1_reg <= u_next;
            t1_reg <= issue.t[bzt_pkg::T_BITS-1:0];
            uu_reg <= UU_W'(u_next * u_next);
            tt_reg <= UU_W'(issue.t[bzt_pkg::T_BITS-1:0] * issue.t[bzt_pkg::T_BITS-1:0]);
            // stage 2: cubes
            a_reg[0] <= A_W'(uu_reg * u1_reg);
            a_reg[1] <= A_W'(uu_reg * t1_reg);
            a_reg[2] <= A_W'(tt_reg * u1_reg);
            a_reg[3] <= A_W'(tt_reg * t1_reg);
            // stage 3: scale and round weights
            w_reg <= w_next;
            // stage 4: weight times coordinate
            for (int k = 0; k < 4; k++) begin
                px_reg[k] <= PR_W'($signed({1'b0, w_reg[k]}) * $signed(p_reg[3].px[k]));
                py_reg[k] <= PR_W'($signed({1'b0, w_reg[k]}) * $signed(p_reg[3].py[k]));
            end
            // stage 5: sum
            sx_reg <= S_W'(px_reg[0]) + S_W'(px_reg[1]) + S_W'(px_reg[2]) + S_W'(px_reg[3]);
            sy_reg <= S_W'(py_reg[0]) + S_W'(py_reg[1]) + S_W'(py_reg[2]) + S_W'(py_reg[3]);
            // stage 6: output register
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oi_reg <= i_reg[5];
            ol_reg <= l_reg[5];
        end
    end

    assign m_valid       = ov_reg;
    assign m_point_x     = ox_reg;
    assign m_point_y     = oy_reg;
    assign m_point_index = oi_reg;
    assign m_last_point  = ol_reg;

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during stall");
    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[3] && !l_reg[3]) |-> (w_reg[0] <= WT_W'(2 ** bzt_pkg::W_BITS)))
        else $error("start weight out of range");
    a_en_def: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_ready) |-> !en)
        else $error("pipeline advanced over an untaken result");
`endif

endmodule

// ===== rtl/core/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator. A curve transaction with segment count N first
// passes through a bit-serial divider that forms 2^16/N (skipped when N is zero),
// then N+1 samples are issued, one per cycle while the result side takes them;
// the next transaction is accepted in the cycle after the last sample has been
// issued. Results leave a six-stage evaluation pipeline, the last stage being
// the output register.
// Top level; instantiates bzt_seq and bzt_pipe, uses bzt_pkg.
module cubic_bezier_tessellator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_a_x,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_a_y,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_b_x,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_b_y,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [bzt_pkg::COORD_W-1:0] s_end_y,
    input  logic [bzt_pkg::IDX_W-1:0]          s_segment_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bzt_pkg::COORD_W-1:0] m_point_x,
    output logic signed [bzt_pkg::COORD_W-1:0] m_point_y,
    output logic [bzt_pkg::IDX_W-1:0]          m_point_index,
    output logic                               m_last_point
);

    bzt_pkg::ctrl_pts_t pts_in;
    bzt_pkg::ctrl_pts_t pts;
    bzt_pkg::issue_t    issue;
    logic               en;

    assign pts_in.px = {s_end_x, s_ctrl_b_x, s_ctrl_a_x, s_start_x};
    assign pts_in.py = {s_end_y, s_ctrl_b_y, s_ctrl_a_y, s_start_y};

    bzt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .pts_in  (pts_in),
        .seg_in  (s_segment_count),
        .en      (en),
        .issue   (issue),
        .pts     (pts)
    );

    bzt_pipe u_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue         (issue),
        .pts           (pts),
        .en            (en),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_index (m_point_index),
        .m_last_point  (m_last_point)
    );

endmodule

// ===== tb/sv/cubic_bezier_tessellator_test.sv =====
// Self-checking testbench for cubic_bezier_tessellator: drives curve transactions,
// predicts every sampled point in fixed point and compares the result stream.
// Depends on bzt_pkg and the tessellator RTL.
module cubic_bezier_tessellator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [bzt_pkg::COORD_W-1:0] px[4];
        logic signed [bzt_pkg::COORD_W-1:0] py[4];
        logic [bzt_pkg::IDX_W-1:0]          segs;
    } curve_t;

    typedef struct {
        logic signed [bzt_pkg::COORD_W-1:0] x;
        logic signed [bzt_pkg::COORD_W-1:0] y;
        logic [bzt_pkg::IDX_W-1:0]          idx;
        logic                               last;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [bzt_pkg::COORD_W-1:0] s_start_x = '0, s_start_y = '0;
    logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_a_x = '0, s_ctrl_a_y = '0;
    logic signed [bzt_pkg::COORD_W-1:0] s_ctrl_b_x = '0, s_ctrl_b_y = '0;
    logic signed [bzt_pkg::COORD_W-1:0] s_end_x = '0, s_end_y = '0;
    logic [bzt_pkg::IDX_W-1:0] s_segment_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [bzt_pkg::COORD_W-1:0] m_point_x, m_point_y;
    logic [bzt_pkg::IDX_W-1:0] m_point_index;
    logic m_last_point;

    cubic_bezier_tessellator uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    curve_t curve_q[$];
    point_t expected_pts[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    logic   hold_active = 1'b0;
    int     mismatches = 0;
    int     points_seen = 0;
    int     curves_sent = 0;

    function automatic logic signed [bzt_pkg::COORD_W-1:0] blend_coord(
        logic [63:0] w[4], logic signed [bzt_pkg::COORD_W-1:0] p[4]);
        logic signed [63:0] acc;
        logic signed [63:0] q;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += $signed(w[k]) * 64'(p[k]);
        q = (acc + (64'sd1 <<< (bzt_pkg::W_BITS - 1))) >>> bzt_pkg::W_BITS;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        return q[bzt_pkg::COORD_W-1:0];
    endfunction

    task automatic predict_curve(curve_t c);
        logic [63:0] n, t, u, w[4];
        point_t pt;
        n = 64'(c.segs);
        for (longint unsigned i = 0; i < n; i++) begin
            t = ((i << bzt_pkg::T_BITS) + n / 2) / n;
            u = (64'd1 << bzt_pkg::T_BITS) - t;
            w[0] = (u * u * u + (64'd1 << 17)) >> 18;
            w[1] = (3 * u * u * t + (64'd1 << 17)) >> 18;
            w[2] = (3 * u * t * t + (64'd1 << 17)) >> 18;
            w[3] = (t * t * t + (64'd1 << 17)) >> 18;
            pt.x = blend_coord(w, c.px);
            pt.y = blend_coord(w, c.py);
            pt.idx = bzt_pkg::IDX_W'(i);
            pt.last = 1'b0;
            expected_pts = {expected_pts, pt};
        end
        pt.x = c.px[3];
        pt.y = c.py[3];
        pt.idx = c.segs;
        pt.last = 1'b1;
        expected_pts = {expected_pts, pt};
    endtask

    // Hold the receiver off for a fixed number of cycles.
    task automatic hold_receiver(int cycles);
        hold_active = 1'b1;
        repeat (cycles) @(posedge aclk);
        hold_active = 1'b0;
    endtask

    // Driver: advance the curve queue, hold the payload until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) begin
                    predict_curve(curve_q.pop_front());
                    curves_sent++;
                end
                if (curve_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_start_x <= curve_q[0].px[0];
                    s_start_y <= curve_q[0].py[0];
                    s_ctrl_a_x <= curve_q[0].px[1];
                    s_ctrl_a_y <= curve_q[0].py[1];
                    s_ctrl_b_x <= curve_q[0].px[2];
                    s_ctrl_b_y <= curve_q[0].py[2];
                    s_end_x <= curve_q[0].px[3];
                    s_end_y <= curve_q[0].py[3];
                    s_segment_count <= curve_q[0].segs;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each point transaction against the oldest prediction.
    always @(posedge aclk) begin
        point_t exp_pt;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                points_seen++;
                if (expected_pts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point x=%0d y=%0d idx=%0d last=%0b",
                                 m_point_x, m_point_y, m_point_index, m_last_point);
                end else begin
                    exp_pt = expected_pts.pop_front();
                    if (m_point_x !== exp_pt.x || m_point_y !== exp_pt.y ||
                        m_point_index !== exp_pt.idx || m_last_point !== exp_pt.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"point mismatch: exp x=%0d y=%0d idx=%0d last=%0b,",
                                      " got x=%0d y=%0d idx=%0d last=%0b"},
                                     exp_pt.x, exp_pt.y, exp_pt.idx, exp_pt.last,
                                     m_point_x, m_point_y, m_point_index, m_last_point);
                    end
                end
            end
            if (hold_active) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [bzt_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return 24'sh7fffff;
            1: return -24'sh800000;
            2: return bzt_pkg::COORD_W'($urandom_range(2000)) - 24'sd1000;
            default: return bzt_pkg::COORD_W'($urandom);
        endcase
    endfunction

    function automatic curve_t rand_curve();
        curve_t c;
        for (int k = 0; k < 4; k++) begin
            c.px[k] = rand_coord();
            c.py[k] = rand_coord();
        end
        // keep most counts small so the run stays short
        c.segs = ($urandom_range(9) == 0) ? bzt_pkg::IDX_W'($urandom_range(63))
                                          : bzt_pkg::IDX_W'($urandom_range(8));
        return c;
    endfunction

    task automatic drain();
        while (curve_q.size() > 0 || s_valid || expected_pts.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        curve_t c;
        int phase_idle[4] = '{0, 76, 0, 19};
        int phase_stall[4] = '{0, 0, 76, 19};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero and full segment counts
        for (int d = 0; d < 20; d++) begin
            for (int k = 0; k < 4; k++) begin
                c.px[k] = (d % 2) ? 24'sh7fffff : -24'sh800000;
                c.py[k] = ((d + k) % 2) ? 24'sh7fffff : -24'sh800000;
            end
            if (d >= 10) c = rand_curve();
            c.segs = (d % 4 == 0) ? '0 : (d % 4 == 1) ? 6'd63 : (d % 4 == 2) ? 6'd1
                                                             : bzt_pkg::IDX_W'(d);
            curve_q = {curve_q, c};
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int k = 0; k < 65; k++)
                curve_q = {curve_q, rand_curve()};
            if (ph == 1) begin
                fork
                    hold_receiver(300);
                join_none
            end
            drain();
        end
        // long receiver hold-off with the sender busy
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(400);
        join_none
        for (int k = 0; k < 10; k++)
            curve_q = {curve_q, rand_curve()};
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d curves, %0d points, idle/stall phases and hold-offs",
                 curves_sent, points_seen);
        if (mismatches == 0 && expected_pts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
